[sv/vab_pkg.sv]
`default_nettype none

package vab_pkg;

    // Default configuration of the top level.
    localparam int COORD_BITS_DEF   = 16;
    localparam int BISECT_STEPS_DEF = 10;

    // Tangent thresholds are unsigned Q11.24 and saturate at 2^35-1.
    localparam int          TAN_BITS = 35;
    localparam int          TAN_FRAC = 24;
    localparam logic [63:0] TAN_MAX  = (64'd1 << TAN_BITS) - 64'd1;

    // Angles are carried in fine units of pi/2^18; a quarter turn is 2^17.
    localparam int FINE_BITS         = 20;
    localparam int FINE_QUARTER_BITS = 17;
    localparam logic [FINE_BITS-1:0] HALF_PI_FINE = FINE_BITS'(1) << FINE_QUARTER_BITS;
    localparam logic [FINE_BITS-1:0] PI_FINE      = FINE_BITS'(1) << (FINE_QUARTER_BITS + 1);
    localparam logic [FINE_BITS-1:0] TWO_PI_FINE  = FINE_BITS'(1) << (FINE_QUARTER_BITS + 2);

    // Output angle in units of pi/4096, rounded half up from fine units.
    localparam int ANGLE_BITS  = 13;
    localparam int ANGLE_SHIFT = 6;
    localparam logic [FINE_BITS-1:0] ANGLE_ROUND = FINE_BITS'(1) << (ANGLE_SHIFT - 1);

    // Largest threshold table that one registered lookup covers.
    localparam int ROM_BANK_BITS = 8;

    localparam logic [63:0] Q62_ONE = 64'd1 << 62;
    localparam logic [63:0] PI_Q62  = 64'hC90F_DAA2_2168_C235;

    // Quadrant folding and axis flags that travel down the pipeline.
    typedef struct packed {
        logic neg_x;
        logic neg_y;
        logic zero_x;
        logic zero_y;
    } vab_flags_t;

    // Low 64 bits of (a * b) >> sh.
    function automatic logic [63:0] mul_shr(input logic [63:0] a, input logic [63:0] b,
                                            input int sh);
        logic [127:0] p;
        logic [127:0] q;
        p = {64'd0, a} * {64'd0, b};
        q = p >> sh;
        return q[63:0];
    endfunction

    // Restoring division, used only while the threshold tables are built.
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] q;
        logic [64:0] r;
        q = '0;
        r = '0;
        for (int i = 63; i >= 0; i--) begin
            r = {r[63:0], num[i]};
            if (r >= {1'b0, den}) begin
                r = r - {1'b0, den};
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // round(2^24 * num / den), saturated; num and den in Q2.62.
    function automatic logic [63:0] ratio_q24(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] hi;
        logic [63:0] lo;
        logic [63:0] lo2;
        logic [63:0] d;
        logic [63:0] rem;
        logic [63:0] q;
        logic        over;
        logic        bitv;
        if (den == 64'd0 || den[63]) begin
            return TAN_MAX;
        end
        hi   = num >> (64 - (TAN_FRAC + 1));
        lo   = num << (TAN_FRAC + 1);
        lo2  = lo + den;
        d    = den << 1;
        rem  = '0;
        q    = '0;
        over = 1'b0;
        if (lo2 < lo) begin
            hi = hi + 64'd1;
        end
        for (int i = 127; i >= 0; i--) begin
            if (i >= 64) begin
                bitv = hi[i-64];
            end else begin
                bitv = lo2[i];
            end
            rem = {rem[62:0], bitv};
            if (q[63]) begin
                over = 1'b1;
            end
            q = {q[62:0], 1'b0};
            if (rem >= d) begin
                rem  = rem - d;
                q[0] = 1'b1;
            end
        end
        if (over || q > TAN_MAX) begin
            return TAN_MAX;
        end
        return q;
    endfunction

    // tan(k * pi / 2^18) in Q11.24 from Taylor series for sin and cos.
    function automatic logic [TAN_BITS-1:0] tan_q24(input logic [63:0] k);
        logic [63:0] m;
        logic [63:0] m2;
        logic [63:0] f;
        logic [63:0] g;
        logic [63:0] r;
        m  = mul_shr(k, PI_Q62, 18);
        m2 = mul_shr(m, m, 62);
        f  = Q62_ONE;
        g  = Q62_ONE;
        for (int n = 14; n >= 1; n--) begin
            f = Q62_ONE - udiv64(mul_shr(m2, f, 62), 64'((2 * n) * (2 * n + 1)));
            g = Q62_ONE - udiv64(mul_shr(m2, g, 62), 64'((2 * n - 1) * (2 * n)));
        end
        r = ratio_q24(mul_shr(m, f, 62), g);
        return r[TAN_BITS-1:0];
    endfunction

endpackage

`default_nettype wire

[sv/vab_step.sv]
`default_nettype none

// One bisection step in four register stages: threshold lookup, bank select,
// multiply, and compare with update of the decided angle bits.
module vab_step #(
    parameter int COORD_BITS   = vab_pkg::COORD_BITS_DEF,
    parameter int BISECT_STEPS = vab_pkg::BISECT_STEPS_DEF,
    parameter int STEP         = 0
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    en,
    input  wire logic                    in_vld,
    input  wire vab_pkg::vab_flags_t     in_flg,
    input  wire logic [COORD_BITS-1:0]   in_ux,
    input  wire logic [COORD_BITS-1:0]   in_uy,
    input  wire logic [BISECT_STEPS-1:0] in_r1,
    output logic                         out_vld,
    output vab_pkg::vab_flags_t          out_flg,
    output logic [COORD_BITS-1:0]        out_ux,
    output logic [COORD_BITS-1:0]        out_uy,
    output logic [BISECT_STEPS-1:0]      out_r1
);

    localparam int TanW   = vab_pkg::TAN_BITS;
    localparam int Depth  = 1 << STEP;
    localparam int LoBits = (STEP < vab_pkg::ROM_BANK_BITS) ? STEP : vab_pkg::ROM_BANK_BITS;
    localparam int HiBits = STEP - LoBits;
    localparam int NBank  = 1 << HiBits;
    localparam int ProdW  = COORD_BITS + TanW;
    localparam logic [BISECT_STEPS-1:0] MidBit = BISECT_STEPS'(1) << (BISECT_STEPS - 1 - STEP);

    typedef logic [TanW-1:0] tbl_t [Depth];

    // Thresholds for the midpoints this step can test: the decided bits form
    // the table address, the step's own bit is one, the lower bits are zero.
    function automatic tbl_t build_tbl();
        tbl_t        t;
        logic [63:0] j;
        for (int p = 0; p < Depth; p++) begin
            j = (64'(p) << (BISECT_STEPS - STEP)) | (64'd1 << (BISECT_STEPS - 1 - STEP));
            t[p] = vab_pkg::tan_q24(j << (vab_pkg::FINE_QUARTER_BITS - BISECT_STEPS));
        end
        return t;
    endfunction

    localparam tbl_t TBL = build_tbl();

    logic                      a_vld_reg, b_vld_reg, c_vld_reg, d_vld_reg;
    vab_pkg::vab_flags_t       a_flg_reg, b_flg_reg, c_flg_reg, d_flg_reg;
    logic [COORD_BITS-1:0]     a_ux_reg, b_ux_reg, c_ux_reg, d_ux_reg;
    logic [COORD_BITS-1:0]     a_uy_reg, b_uy_reg, c_uy_reg, d_uy_reg;
    logic [BISECT_STEPS-1:0]   a_r1_reg, b_r1_reg, c_r1_reg, d_r1_reg;
    logic [TanW-1:0]           bank_reg [NBank];
    logic [TanW-1:0]           bank_next [NBank];
    logic [TanW-1:0]           thr_reg, thr_next;
    logic [ProdW-1:0]          prod_reg, prod_next;
    logic [ProdW-1:0]          uy_scaled;
    logic [BISECT_STEPS-1:0]   d_r1_next;

    generate
        if (STEP == 0) begin : g_first
            always_comb begin
                bank_next[0] = TBL[0];
            end
            always_comb begin
                thr_next = bank_reg[0];
            end
        end else if (NBank == 1) begin : g_one_bank
            always_comb begin
                bank_next[0] = TBL[in_r1[BISECT_STEPS-1 -: STEP]];
            end
            always_comb begin
                thr_next = bank_reg[0];
            end
        end else begin : g_banks
            logic [LoBits-1:0] lo_addr;
            assign lo_addr = in_r1[BISECT_STEPS-1-HiBits -: LoBits];
            always_comb begin
                for (int b = 0; b < NBank; b++) begin
                    bank_next[b] = TBL[{HiBits'(b), lo_addr}];
                end
            end
            always_comb begin
                thr_next = bank_reg[a_r1_reg[BISECT_STEPS-1 -: HiBits]];
            end
        end
    endgenerate

    assign prod_next = ProdW'(b_ux_reg) * ProdW'(thr_reg);
    assign uy_scaled = ProdW'({c_uy_reg, {vab_pkg::TAN_FRAC{1'b0}}});
    // The upper half is kept when dy is not below dx * tan(mid).
    assign d_r1_next = (uy_scaled >= prod_reg) ? (c_r1_reg | MidBit) : c_r1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            c_vld_reg <= 1'b0;
            d_vld_reg <= 1'b0;
        end else if (en) begin
            a_vld_reg <= in_vld;
            b_vld_reg <= a_vld_reg;
            c_vld_reg <= b_vld_reg;
            d_vld_reg <= c_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_flg_reg <= in_flg;
            a_ux_reg  <= in_ux;
            a_uy_reg  <= in_uy;
            a_r1_reg  <= in_r1;
            for (int b = 0; b < NBank; b++) begin
                bank_reg[b] <= bank_next[b];
            end
            b_flg_reg <= a_flg_reg;
            b_ux_reg  <= a_ux_reg;
            b_uy_reg  <= a_uy_reg;
            b_r1_reg  <= a_r1_reg;
            thr_reg   <= thr_next;
            c_flg_reg <= b_flg_reg;
            c_ux_reg  <= b_ux_reg;
            c_uy_reg  <= b_uy_reg;
            c_r1_reg  <= b_r1_reg;
            prod_reg  <= prod_next;
            d_flg_reg <= c_flg_reg;
            d_ux_reg  <= c_ux_reg;
            d_uy_reg  <= c_uy_reg;
            d_r1_reg  <= d_r1_next;
        end
    end

    assign out_vld = d_vld_reg;
    assign out_flg = d_flg_reg;
    assign out_ux  = d_ux_reg;
    assign out_uy  = d_uy_reg;
    assign out_r1  = d_r1_reg;

    // Bits below this step's midpoint are never set yet.
    a_low_bits_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        d_vld_reg |-> ((d_r1_reg & (MidBit - BISECT_STEPS'(1))) == '0))
        else $error("bisection bits below the current step are set");

endmodule

`default_nettype wire

[sv/vector_angle_bisection.sv]
`default_nettype none

// Angle of a vector by bisection against a tangent table.
//
// The input channel (s_tvalid, s_tready, s_tdata) carries a point and an
// origin; each transfer yields exactly one transfer on the result channel
// (m_tvalid, m_tready, m_tdata) holding the angle of point minus origin,
// counterclockwise from the +x axis in units of pi/4096, in input order.
//
// The difference is registered at the input transfer and folded in the next
// stage; each bisection step registers a table lookup, a bank select, a
// multiply and a compare; a final stage builds the folded angle and the
// output register holds the result.
// A new item is accepted in every cycle while s_tready is high; every stage,
// the per-step multiplier included, is used once per item: one per cycle.
//
// Reset clears only the valid bits; the tangent tables are constant logic,
// so the block accepts items as soon as reset is released.
// When the receiver stalls, one result spills into a skid register behind
// the output register and s_tready then falls, which freezes the whole
// pipeline until the receiver takes a result. Nothing is lost or repeated.
module vector_angle_bisection #(
    parameter int COORD_BITS   = vab_pkg::COORD_BITS_DEF,
    parameter int BISECT_STEPS = vab_pkg::BISECT_STEPS_DEF
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_tvalid,
    output logic      s_tready,
    // Fields from bit 0 up: point_x, point_y, origin_x, origin_y, then zero fill.
    input  wire logic [((4 * COORD_BITS + 7) / 8) * 8 - 1:0] s_tdata,
    output logic      m_tvalid,
    input  wire logic m_tready,
    // Fields from bit 0 up: angle_units, then zero fill.
    output logic [((vab_pkg::ANGLE_BITS + 7) / 8) * 8 - 1:0] m_tdata
);

    localparam int FineW  = vab_pkg::FINE_BITS;
    localparam int AngW   = vab_pkg::ANGLE_BITS;
    localparam int MOutW  = ((AngW + 7) / 8) * 8;
    localparam int DiffW  = COORD_BITS + 1;

    // The whole pipeline advances together while the skid register is empty.
    logic en;

    // Stage 0: coordinate differences.
    logic signed [COORD_BITS-1:0] point_x, point_y, origin_x, origin_y;
    logic                         s0_vld_reg;
    logic signed [DiffW-1:0]      s0_dx_reg, s0_dy_reg, s0_dx_next, s0_dy_next;

    // Stage 1: magnitudes and quadrant flags.
    logic                    s1_vld_reg;
    vab_pkg::vab_flags_t     s1_flg_reg, s1_flg_next;
    logic [COORD_BITS-1:0]   s1_ux_reg, s1_uy_reg, s1_ux_next, s1_uy_next;
    logic [DiffW-1:0]        abs_dx, abs_dy;

    // Boundaries between bisection steps; index 0 is stage 1.
    logic                    stg_vld [BISECT_STEPS+1];
    vab_pkg::vab_flags_t     stg_flg [BISECT_STEPS+1];
    logic [COORD_BITS-1:0]   stg_ux  [BISECT_STEPS+1];
    logic [COORD_BITS-1:0]   stg_uy  [BISECT_STEPS+1];
    logic [BISECT_STEPS-1:0] stg_r1  [BISECT_STEPS+1];

    // Final stage: first-quadrant angle and the x fold.
    logic                    f_vld_reg;
    logic                    f_negy_reg;
    logic [FineW-1:0]        f_ang_reg, f_ang_next;
    logic [FineW-1:0]        base_ang;
    logic [FineW-1:0]        full_ang;
    logic [FineW-1:0]        rounded;
    logic [AngW-1:0]         res_ang;

    // Output register and skid register.
    logic                    out_vld_reg, skid_vld_reg;
    logic [AngW-1:0]         out_ang_reg, skid_ang_reg;
    logic                    take, push;

    assign en       = !skid_vld_reg;
    assign s_tready = en;

    assign point_x  = s_tdata[COORD_BITS-1:0];
    assign point_y  = s_tdata[2*COORD_BITS-1:COORD_BITS];
    assign origin_x = s_tdata[3*COORD_BITS-1:2*COORD_BITS];
    assign origin_y = s_tdata[4*COORD_BITS-1:3*COORD_BITS];

    assign s0_dx_next = DiffW'(point_x) - DiffW'(origin_x);
    assign s0_dy_next = DiffW'(point_y) - DiffW'(origin_y);

    // The magnitude of a difference always fits in COORD_BITS bits.
    assign abs_dx = s0_dx_reg[DiffW-1] ? DiffW'(-s0_dx_reg) : DiffW'(s0_dx_reg);
    assign abs_dy = s0_dy_reg[DiffW-1] ? DiffW'(-s0_dy_reg) : DiffW'(s0_dy_reg);
    assign s1_ux_next = abs_dx[COORD_BITS-1:0];
    assign s1_uy_next = abs_dy[COORD_BITS-1:0];

    always_comb begin
        s1_flg_next.neg_x  = s0_dx_reg[DiffW-1];
        s1_flg_next.neg_y  = s0_dy_reg[DiffW-1];
        s1_flg_next.zero_x = (s0_dx_reg == '0);
        s1_flg_next.zero_y = (s0_dy_reg == '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s0_vld_reg <= 1'b0;
            s1_vld_reg <= 1'b0;
            f_vld_reg  <= 1'b0;
        end else if (en) begin
            s0_vld_reg <= s_tvalid;
            s1_vld_reg <= s0_vld_reg;
            f_vld_reg  <= stg_vld[BISECT_STEPS];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s0_dx_reg  <= s0_dx_next;
            s0_dy_reg  <= s0_dy_next;
            s1_flg_reg <= s1_flg_next;
            s1_ux_reg  <= s1_ux_next;
            s1_uy_reg  <= s1_uy_next;
            f_ang_reg  <= f_ang_next;
            f_negy_reg <= stg_flg[BISECT_STEPS].neg_y;
        end
    end

    assign stg_vld[0] = s1_vld_reg;
    assign stg_flg[0] = s1_flg_reg;
    assign stg_ux[0]  = s1_ux_reg;
    assign stg_uy[0]  = s1_uy_reg;
    assign stg_r1[0]  = '0;

    generate
        for (genvar s = 0; s < BISECT_STEPS; s++) begin : g_step
            vab_step #(
                .COORD_BITS  (COORD_BITS),
                .BISECT_STEPS(BISECT_STEPS),
                .STEP        (s)
            ) u_step (
                .aclk   (aclk),
                .aresetn(aresetn),
                .en     (en),
                .in_vld (stg_vld[s]),
                .in_flg (stg_flg[s]),
                .in_ux  (stg_ux[s]),
                .in_uy  (stg_uy[s]),
                .in_r1  (stg_r1[s]),
                .out_vld(stg_vld[s+1]),
                .out_flg(stg_flg[s+1]),
                .out_ux (stg_ux[s+1]),
                .out_uy (stg_uy[s+1]),
                .out_r1 (stg_r1[s+1])
            );
        end
    endgenerate

    // The answer is the midpoint of the final interval. A vector on the y axis
    // (the zero vector included) starts at a quarter turn, on the x axis at zero.
    always_comb begin
        priority if (stg_flg[BISECT_STEPS].zero_x) begin
            base_ang = vab_pkg::HALF_PI_FINE;
        end else if (stg_flg[BISECT_STEPS].zero_y) begin
            base_ang = '0;
        end else begin
            base_ang = (FineW'(stg_r1[BISECT_STEPS])
                        << (vab_pkg::FINE_QUARTER_BITS - BISECT_STEPS))
                     | (FineW'(1) << (vab_pkg::FINE_QUARTER_BITS - 1 - BISECT_STEPS));
        end
    end

    assign f_ang_next = stg_flg[BISECT_STEPS].neg_x ? (vab_pkg::PI_FINE - base_ang) : base_ang;

    // The y fold, then rounding half up; a full turn wraps to zero.
    assign full_ang = f_negy_reg ? (vab_pkg::TWO_PI_FINE - f_ang_reg) : f_ang_reg;
    assign rounded  = full_ang + vab_pkg::ANGLE_ROUND;
    assign res_ang  = rounded[vab_pkg::ANGLE_SHIFT + AngW - 1:vab_pkg::ANGLE_SHIFT];

    assign take = out_vld_reg && m_tready;
    assign push = en && f_vld_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end else begin
            if (skid_vld_reg) begin
                if (take) begin
                    skid_vld_reg <= 1'b0;
                end
            end else if (push) begin
                if (!out_vld_reg || take) begin
                    out_vld_reg <= 1'b1;
                end else begin
                    skid_vld_reg <= 1'b1;
                end
            end else if (take) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_vld_reg) begin
            if (take) begin
                out_ang_reg <= skid_ang_reg;
            end
        end else if (push) begin
            if (!out_vld_reg || take) begin
                out_ang_reg <= res_ang;
            end else begin
                skid_ang_reg <= res_ang;
            end
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = MOutW'(out_ang_reg);

    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_vld_reg |-> out_vld_reg)
        else $error("skid register holds a result while the output register is empty");

    a_spill_to_skid: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && out_vld_reg && !m_tready) |=> skid_vld_reg)
        else $error("result leaving the pipeline during a stall was not kept");

    a_skid_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        (skid_vld_reg && m_tready) |=> (out_vld_reg && !skid_vld_reg))
        else $error("skid register did not move into the output register");

endmodule

`default_nettype wire
